/* src/mrlte_pkg.sv */
// ----------------------------------------------------------------------------
// mrlte_pkg: shared types and constants of the run-length text encoder
// Item kinds, direction codes, ASCII codes and the character group that the
// formatter hands to the output buffer.
// ----------------------------------------------------------------------------
package mrlte_pkg;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_EOL      = 2'd1,
    KIND_WORD     = 2'd2,
    KIND_INITIALS = 2'd3
  } kind_t;

  // Direction codes; codes above JOY_DOWN count as no movement.
  localparam logic [2:0] JOY_NONE  = 3'd0;
  localparam logic [2:0] JOY_RIGHT = 3'd1;
  localparam logic [2:0] JOY_UP    = 3'd2;
  localparam logic [2:0] JOY_LEFT  = 3'd3;
  localparam logic [2:0] JOY_DOWN  = 3'd4;

  // ASCII codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_UPPER_O = 8'h4F;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_L = 8'h6C;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  // Most characters that one item can produce.
  localparam int MAX_CHARS = 9;
  localparam int COUNT_W   = 4;
  localparam int COLUMN_W  = 7;

  // Run length held as three BCD digits: hundreds, tens, ones.
  localparam logic [11:0] BCD_ZERO = 12'h000;
  localparam logic [11:0] BCD_ONE  = 12'h001;

  // Encoder state carried from item to item.
  typedef struct packed {
    logic [7:0]          symbol;
    logic [11:0]         run_bcd;
    logic [COLUMN_W-1:0] column;
  } enc_state_t;

  // Characters produced by one item; entry 0 goes out first.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [COUNT_W-1:0]        count;
  } char_group_t;

endpackage

/* src/mrlte_format.sv */
// ----------------------------------------------------------------------------
// mrlte_format: character formatter
// Turns one item and the current run state into its group of characters and
// the next run state, in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module mrlte_format #(
  parameter int LINE_LIMIT = 60,
  parameter int RUN_LIMIT  = 999
) (
  input  mrlte_pkg::kind_t      kind,
  input  logic [2:0]            direction,
  input  logic                  fire,
  input  logic [31:0]           word_value,
  input  mrlte_pkg::enc_state_t st,
  output mrlte_pkg::enc_state_t st_nxt,
  output mrlte_pkg::char_group_t group
);

  localparam logic [7:0]  LINE_LIMIT_W  = 8'(LINE_LIMIT);
  localparam logic [11:0] RUN_LIMIT_BCD = {4'(RUN_LIMIT / 100), 4'((RUN_LIMIT / 10) % 10),
                                           4'(RUN_LIMIT % 10)};

  typedef struct packed {
    logic [4:0][7:0]                   chars;
    logic [2:0]                        len;
    logic [mrlte_pkg::COLUMN_W-1:0]    col;
  } run_text_t;

  function automatic logic [7:0] dir_letter(input logic [2:0] dir, input logic fire_in);
    logic [7:0] c;
    unique case (dir)
      mrlte_pkg::JOY_RIGHT: c = mrlte_pkg::CH_LOWER_R;
      mrlte_pkg::JOY_UP:    c = mrlte_pkg::CH_LOWER_U;
      mrlte_pkg::JOY_LEFT:  c = mrlte_pkg::CH_LOWER_L;
      mrlte_pkg::JOY_DOWN:  c = mrlte_pkg::CH_LOWER_D;
      default:              c = mrlte_pkg::CH_LOWER_S;
    endcase
    return fire_in ? c - mrlte_pkg::CASE_SHIFT : c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (mrlte_pkg::CH_ZERO + {4'h0, nib})
                         : (mrlte_pkg::CH_UPPER_A + {4'h0, nib} - 8'd10);
  endfunction

  function automatic logic [11:0] bcd_inc(input logic [11:0] v);
    logic [11:0] r;
    r = v;
    if (v[3:0] != 4'd9) begin
      r[3:0] = v[3:0] + 4'd1;
    end else begin
      r[3:0] = 4'd0;
      if (v[7:4] != 4'd9) begin
        r[7:4] = v[7:4] + 4'd1;
      end else begin
        r[7:4]  = 4'd0;
        r[11:8] = v[11:8] + 4'd1;
      end
    end
    return r;
  endfunction

  // Letter, decimal count when above one, and a newline on line wrap.
  function automatic run_text_t run_text(input logic [7:0] sym, input logic [11:0] bcd,
                                         input logic [mrlte_pkg::COLUMN_W-1:0] column);
    run_text_t r;
    logic [2:0] len;
    logic [7:0] col;
    r          = '0;
    r.chars[0] = sym;
    len        = 3'd1;
    if (bcd > mrlte_pkg::BCD_ONE) begin
      if (bcd[11:8] != 4'd0) begin
        r.chars[len] = mrlte_pkg::CH_ZERO | {4'h0, bcd[11:8]};
        len          = len + 3'd1;
      end
      if (bcd[11:4] != 8'd0) begin
        r.chars[len] = mrlte_pkg::CH_ZERO | {4'h0, bcd[7:4]};
        len          = len + 3'd1;
      end
      r.chars[len] = mrlte_pkg::CH_ZERO | {4'h0, bcd[3:0]};
      len          = len + 3'd1;
    end
    col = {1'b0, column} + {5'b0, len};
    if (col >= LINE_LIMIT_W) begin
      r.chars[len] = mrlte_pkg::CH_NL;
      len          = len + 3'd1;
      col          = 8'd0;
    end
    r.len = len;
    r.col = col[mrlte_pkg::COLUMN_W-1:0];
    return r;
  endfunction

  always_comb begin
    run_text_t                      rt;
    logic [7:0]                     letter;
    logic [7:0]                     cur_sym;
    logic [mrlte_pkg::COUNT_W-1:0]  n;
    logic [mrlte_pkg::COLUMN_W-1:0] col;
    letter  = dir_letter(direction, fire);
    cur_sym = (st.run_bcd == mrlte_pkg::BCD_ZERO) ? letter : st.symbol;
    rt      = run_text(cur_sym, st.run_bcd, st.column);
    st_nxt  = st;
    group   = '0;
    n       = '0;
    col     = st.column;
    unique case (kind)
      mrlte_pkg::KIND_SAMPLE: begin
        st_nxt.symbol = cur_sym;
        if (cur_sym != letter || st.run_bcd >= RUN_LIMIT_BCD) begin
          group.chars[4:0] = rt.chars;
          group.count      = mrlte_pkg::COUNT_W'(rt.len);
          st_nxt.column    = rt.col;
          st_nxt.symbol    = letter;
          st_nxt.run_bcd   = mrlte_pkg::BCD_ONE;
        end else begin
          st_nxt.run_bcd = bcd_inc(st.run_bcd);
        end
      end
      mrlte_pkg::KIND_EOL: begin
        // The open run is written but stays open; only the column moves on.
        if (st.run_bcd != mrlte_pkg::BCD_ZERO) begin
          group.chars[4:0] = rt.chars;
          n                = mrlte_pkg::COUNT_W'(rt.len);
          col              = rt.col;
          st_nxt.column    = rt.col;
        end
        if (col != '0) begin
          group.chars[n] = mrlte_pkg::CH_NL;
          n              = n + mrlte_pkg::COUNT_W'(1);
        end
        group.chars[n] = mrlte_pkg::CH_UPPER_E;
        n              = n + mrlte_pkg::COUNT_W'(1);
        group.chars[n] = mrlte_pkg::CH_UPPER_O;
        n              = n + mrlte_pkg::COUNT_W'(1);
        group.chars[n] = mrlte_pkg::CH_UPPER_L;
        n              = n + mrlte_pkg::COUNT_W'(1);
        group.chars[n] = mrlte_pkg::CH_NL;
        n              = n + mrlte_pkg::COUNT_W'(1);
        group.count    = n;
      end
      mrlte_pkg::KIND_WORD: begin
        for (int i = 0; i < 8; i++) begin
          group.chars[i] = hex_char(word_value[31-4*i -: 4]);
        end
        group.chars[8] = mrlte_pkg::CH_NL;
        group.count    = mrlte_pkg::COUNT_W'(9);
        st_nxt.run_bcd = mrlte_pkg::BCD_ZERO;
        st_nxt.column  = '0;
      end
      mrlte_pkg::KIND_INITIALS: begin
        group.chars[0] = mrlte_pkg::CH_STAR;
        group.chars[1] = word_value[23:16];
        group.chars[2] = word_value[15:8];
        group.chars[3] = word_value[7:0];
        group.chars[4] = mrlte_pkg::CH_NL;
        group.count    = mrlte_pkg::COUNT_W'(5);
      end
      default: begin
        group = '0;
      end
    endcase
  end

endmodule

/* src/mrlte_out_buf.sv */
// ----------------------------------------------------------------------------
// mrlte_out_buf: output character buffer
// Holds the characters of one item and sends them one beat at a time, marking
// the final character of the group.
// ----------------------------------------------------------------------------
module mrlte_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  mrlte_pkg::char_group_t group,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_text_char,
  output logic                   out_last_char
);

  logic [mrlte_pkg::MAX_CHARS-1:0][7:0] chars_r, chars_nxt;
  logic [mrlte_pkg::COUNT_W-1:0]        rem_r, rem_nxt;
  logic                                 beat;

  assign out_valid     = (rem_r != '0);
  assign beat          = out_valid && out_ready;
  assign out_text_char = chars_r[0];
  assign out_last_char = (rem_r == mrlte_pkg::COUNT_W'(1));
  // The buffer can take a new group once its last character leaves.
  assign free          = (rem_r == '0) || (out_last_char && out_ready);

  always_comb begin
    chars_nxt = chars_r;
    rem_nxt   = rem_r;
    if (load) begin
      chars_nxt = group.chars;
      rem_nxt   = group.count;
    end else if (beat) begin
      chars_nxt = {8'h00, chars_r[mrlte_pkg::MAX_CHARS-1:1]};
      rem_nxt   = rem_r - mrlte_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
  end

endmodule

/* src/move_run_length_text_encoder.sv */
// ----------------------------------------------------------------------------
// move_run_length_text_encoder: joystick recording to run-length ASCII text
// Accepts direction samples, end-of-level marks, random words and initials,
// and delivers the recorded text one character per beat.
// ----------------------------------------------------------------------------
// An item produces N characters (0 to 9): the output side delivers one
// character per beat, and that single output port sets the rate. A sample
// that merely extends the open run produces nothing. An accepted item waits
// in an input register while the previous item's characters drain; when the
// output buffer frees up, the formatter turns it into its whole group of
// characters in one pass, updates the run and column state, and the input
// register takes the next item in the same cycle. The final character of each
// item's group carries out_last_char. Run lengths are kept as three decimal
// digits so that the count can be written without any division.
// ----------------------------------------------------------------------------
module move_run_length_text_encoder #(
  parameter int LINE_LIMIT = 60,
  parameter int RUN_LIMIT  = 999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_direction,
  input  logic        in_fire,
  input  logic [31:0] in_word_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_text_char,
  output logic        out_last_char
);

  // Input register: one item waiting for the formatter.
  logic                  hold_valid_r, hold_valid_nxt;
  mrlte_pkg::kind_t      hold_kind_r;
  logic [2:0]            hold_direction_r;
  logic                  hold_fire_r;
  logic [31:0]           hold_word_r;

  // Run and column state.
  mrlte_pkg::enc_state_t st_r, st_nxt;

  mrlte_pkg::char_group_t group;
  logic                   free;
  logic                   load;
  logic                   in_beat;

  // The held item is formatted as soon as the output buffer can take it.
  assign load     = hold_valid_r && free;
  assign in_ready = !hold_valid_r || load;
  assign in_beat  = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_beat) begin
      hold_valid_nxt = 1'b1;
    end else if (load) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      st_r         <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      hold_kind_r      <= mrlte_pkg::kind_t'(in_kind);
      hold_direction_r <= in_direction;
      hold_fire_r      <= in_fire;
      hold_word_r      <= in_word_value;
    end
  end

  mrlte_format #(
    .LINE_LIMIT (LINE_LIMIT),
    .RUN_LIMIT  (RUN_LIMIT)
  ) u_format (
    .kind       (hold_kind_r),
    .direction  (hold_direction_r),
    .fire       (hold_fire_r),
    .word_value (hold_word_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .group      (group)
  );

  mrlte_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .group         (group),
    .free          (free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule
